// ===== hdl/quadratic_root_solver_unit_macros.svh =====
// Assertion macros for the quadratic root solver RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QRS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRS_ASSERT(label, clk, rst_n, prop, msg)
`define QRS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/qrs_pkg.sv =====
// Package for the quadratic root solver: payload types, sizes and count codes.
// Depends on nothing.
`default_nettype none
package qrs_pkg;
    localparam int COEF_W = 32;
    localparam int FRAC_W = 16;
    localparam int MAG_W = 2 * COEF_W + 3;
    localparam int SQ_W = COEF_W + 1;
    localparam int QDIV_W = MAG_W + FRAC_W;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;
    localparam logic [1:0] CNT_ANY = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_quad;
        logic signed [COEF_W-1:0] coef_lin;
        logic signed [COEF_W-1:0] coef_const;
    } qrs_in_t;

    typedef struct packed {
        logic [1:0] root_count;
        logic signed [COEF_W-1:0] root_first;
        logic signed [COEF_W-1:0] root_second;
        logic saturated;
    } qrs_out_t;

    // Work carried from cell to cell along the chain.
    typedef struct packed {
        logic [1:0] count;
        logic lin;
        logic [MAG_W-1:0] disc;
        logic [SQ_W-1:0] root;
        logic [SQ_W+1:0] rem;
        logic [COEF_W-1:0] mb;
        logic sb;
        logic [COEF_W:0] den;
        logic sden;
        logic n1s;
        logic n2s;
        logic [QDIV_W-1:0] n1;
        logic [QDIV_W-1:0] n2;
        logic [QDIV_W-1:0] q1;
        logic [QDIV_W-1:0] q2;
        logic [QDIV_W:0] r1;
        logic [QDIV_W:0] r2;
    } qrs_work_t;
endpackage
`default_nettype wire

// ===== hdl/quadratic_root_solver_unit.sv =====
// Quadratic root solver top level: front end, square root chain, divider chain.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the macros header.
//
// The solver accepts one transaction per cycle unless a finished result waits.
// Each transaction passes through 3*COEF_W + FRAC_W + 8 register stages (120 for
// Q16.16): two front end stages, the square root chain of one cell per result bit,
// one numerator stage, the restoring divider chain of one cell per quotient bit and
// the output register. The whole pipe advances together and holds while a finished
// result is not taken.
`default_nettype none
`include "quadratic_root_solver_unit_macros.svh"
module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire qrs_in_t in_data,
    output logic out_valid,
    input wire logic out_ready,
    output qrs_out_t out_data
);
    localparam int NSQ = SQ_W;
    localparam int NDV = QDIV_W;
    localparam logic [COEF_W-1:0] HALF = {1'b1, {(COEF_W-1){1'b0}}};

    logic en;

    // Stage A: magnitudes and products.
    logic va_reg, vb_reg;
    logic sa_reg, sb_reg, sc_reg;
    logic [COEF_W-1:0] ma_reg, mb_reg, mc_reg;
    logic [2*COEF_W-1:0] b2_reg, ac_reg;
    logic [COEF_W-1:0] ma_a, mb_a, mc_a;
    logic [COEF_W-1:0] mb_b, ma_b;
    logic sa_b, sb_b;
    logic [MAG_W-1:0] disc_b_reg;
    logic dneg_b_reg, az_b_reg, bz_b_reg, cz_b_reg;
    logic [COEF_W-1:0] mc_b_reg, ma_b_reg, mb_b_reg;
    logic sa_b_reg, sb_b_reg, sc_b_reg;
    logic [MAG_W-1:0] ac4, b2e;

    qrs_work_t chain [0:NSQ+NDV+1];
    logic vchain [0:NSQ+NDV+1];
    qrs_work_t pre_w, mid_w;
    qrs_work_t mid_reg;
    logic vmid_reg;
    logic [SQ_W:0] sm1, sm2;
    logic [SQ_W:0] bext, sext;

    qrs_out_t res;
    qrs_out_t out_reg;
    logic vout_reg;
    qrs_work_t fin;
    logic sat1, sat2;
    logic [COEF_W-1:0] r1v, r2v;
    logic neg1, neg2;

    assign en = !vout_reg || out_ready;
    assign in_ready = en;

    function automatic logic [COEF_W-1:0] mag_of(input logic [COEF_W-1:0] v);
        mag_of = v[COEF_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign ma_a = mag_of(in_data.coef_quad);
    assign mb_a = mag_of(in_data.coef_lin);
    assign mc_a = mag_of(in_data.coef_const);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg <= in_data.coef_quad[COEF_W-1];
            sb_reg <= in_data.coef_lin[COEF_W-1];
            sc_reg <= in_data.coef_const[COEF_W-1];
            ma_reg <= ma_a;
            mb_reg <= mb_a;
            mc_reg <= mc_a;
            b2_reg <= mb_a * mb_a;
            ac_reg <= ma_a * mc_a;
        end
    end

    assign ac4 = {1'b0, ac_reg, 2'b00};
    assign b2e = {3'b000, b2_reg};
    assign ma_b = ma_reg;
    assign mb_b = mb_reg;
    assign sa_b = sa_reg;
    assign sb_b = sb_reg;

    // Stage B: discriminant and zero tests.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sa_reg != sc_reg)
            begin
                disc_b_reg <= b2e + ac4;
                dneg_b_reg <= 1'b0;
            end
            else if (ac4 > b2e)
            begin
                disc_b_reg <= ac4 - b2e;
                dneg_b_reg <= 1'b1;
            end
            else
            begin
                disc_b_reg <= b2e - ac4;
                dneg_b_reg <= 1'b0;
            end
            az_b_reg <= (ma_b == '0);
            bz_b_reg <= (mb_b == '0);
            cz_b_reg <= (mc_reg == '0);
            ma_b_reg <= ma_b;
            mb_b_reg <= mb_b;
            mc_b_reg <= mc_reg;
            sa_b_reg <= sa_b;
            sb_b_reg <= sb_b;
            sc_b_reg <= sc_reg;
        end
    end

    always_comb
    begin
        pre_w = '0;
        pre_w.mb = mb_b_reg;
        pre_w.sb = sb_b_reg;
        pre_w.disc = disc_b_reg;
        pre_w.sden = sa_b_reg;
        if (!az_b_reg)
        begin
            pre_w.lin = 1'b0;
            pre_w.den = {ma_b_reg, 1'b0};
            if (dneg_b_reg)
                pre_w.count = CNT_NONE;
            else if (disc_b_reg == '0)
                pre_w.count = CNT_ONE;
            else
                pre_w.count = CNT_TWO;
        end
        else if (!bz_b_reg)
        begin
            pre_w.lin = 1'b1;
            pre_w.count = CNT_ONE;
            pre_w.den = {1'b0, mb_b_reg};
            pre_w.sden = sb_b_reg;
            pre_w.disc = '0;
            pre_w.n1 = {{(QDIV_W-COEF_W-FRAC_W){1'b0}}, mc_b_reg, {FRAC_W{1'b0}}};
            pre_w.n1s = !sc_b_reg && !cz_b_reg;
        end
        else
        begin
            pre_w.lin = 1'b1;
            pre_w.count = cz_b_reg ? CNT_ANY : CNT_NONE;
            pre_w.den = {{COEF_W{1'b0}}, 1'b1};
        end
    end

    assign chain[0] = pre_w;
    assign vchain[0] = vb_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NSQ; gi++)
        begin : g_sqrt
            qrs_sqrt_cell #(.STEP(gi)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .vin(vchain[gi]), .din(chain[gi]),
                .vout(vchain[gi+1]), .dout(chain[gi+1])
            );
        end
    endgenerate

    // Numerators -b +/- s, signed magnitude.
    always_comb
    begin
        mid_w = chain[NSQ];
        bext = {{(SQ_W+1-COEF_W){1'b0}}, chain[NSQ].mb};
        sext = {1'b0, chain[NSQ].root};
        sm1 = '0;
        sm2 = '0;
        if (!chain[NSQ].lin)
        begin
            if (chain[NSQ].count == CNT_ONE)
            begin
                sm1 = bext;
                mid_w.n1s = !chain[NSQ].sb && (chain[NSQ].mb != '0);
                mid_w.n2s = mid_w.n1s;
                sm2 = bext;
            end
            else
            begin
                // -b has sign !sb; add +s and -s.
                if (chain[NSQ].sb)
                begin
                    sm1 = bext + sext;
                    mid_w.n1s = 1'b0;
                    if (bext >= sext)
                    begin
                        sm2 = bext - sext;
                        mid_w.n2s = 1'b0;
                    end
                    else
                    begin
                        sm2 = sext - bext;
                        mid_w.n2s = 1'b1;
                    end
                end
                else
                begin
                    sm2 = bext + sext;
                    mid_w.n2s = (sm2 != '0);
                    if (bext > sext)
                    begin
                        sm1 = bext - sext;
                        mid_w.n1s = 1'b1;
                    end
                    else
                    begin
                        sm1 = sext - bext;
                        mid_w.n1s = 1'b0;
                    end
                end
            end
            mid_w.n1 = {{(QDIV_W-SQ_W-1-FRAC_W){1'b0}}, sm1, {FRAC_W{1'b0}}};
            mid_w.n2 = {{(QDIV_W-SQ_W-1-FRAC_W){1'b0}}, sm2, {FRAC_W{1'b0}}};
        end
        mid_w.q1 = '0;
        mid_w.q2 = '0;
        mid_w.r1 = '0;
        mid_w.r2 = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vmid_reg <= 1'b0;
        else if (en)
            vmid_reg <= vchain[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mid_reg <= mid_w;
    end

    assign chain[NSQ+1] = mid_reg;
    assign vchain[NSQ+1] = vmid_reg;

    generate
        for (gi = 0; gi < NDV; gi++)
        begin : g_div
            qrs_div_cell #(.STEP(gi)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en),
                .vin(vchain[NSQ+1+gi]), .din(chain[NSQ+1+gi]),
                .vout(vchain[NSQ+2+gi]), .dout(chain[NSQ+2+gi])
            );
        end
    endgenerate

    // Sign, clamp and encode.
    always_comb
    begin
        fin = chain[NSQ+NDV+1];
        neg1 = fin.n1s != fin.sden;
        neg2 = fin.n2s != fin.sden;
        sat1 = 1'b0;
        sat2 = 1'b0;
        if (fin.q1 > {{(QDIV_W-COEF_W){1'b0}}, HALF - {{(COEF_W-1){1'b0}}, !neg1}})
        begin
            r1v = HALF - {{(COEF_W-1){1'b0}}, !neg1};
            sat1 = 1'b1;
        end
        else
            r1v = fin.q1[COEF_W-1:0];
        if (fin.q2 > {{(QDIV_W-COEF_W){1'b0}}, HALF - {{(COEF_W-1){1'b0}}, !neg2}})
        begin
            r2v = HALF - {{(COEF_W-1){1'b0}}, !neg2};
            sat2 = 1'b1;
        end
        else
            r2v = fin.q2[COEF_W-1:0];
        if (neg1)
            r1v = ~r1v + 1'b1;
        if (neg2)
            r2v = ~r2v + 1'b1;
        res.root_count = fin.count;
        res.root_first = '0;
        res.root_second = '0;
        res.saturated = 1'b0;
        if (fin.count == CNT_TWO)
        begin
            res.root_first = r1v;
            res.root_second = r2v;
            res.saturated = sat1 || sat2;
        end
        else if (fin.count == CNT_ONE)
        begin
            res.root_first = r1v;
            res.root_second = fin.lin ? '0 : r1v;
            res.saturated = sat1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else if (en)
            vout_reg <= vchain[NSQ+NDV+1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= res;
    end

    assign out_valid = vout_reg;
    assign out_data = out_reg;

    `QRS_ASSERT(a_ready_follows_out, clk, rst_n, in_ready == (!out_valid || out_ready), "ready mismatch")
    `QRS_ASSERT(a_hold_on_stall, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_data), "output changed while stalled")
    `QRS_ASSERT(a_no_roots_zero, clk, rst_n, (out_valid && (out_data.root_count == CNT_NONE || out_data.root_count == CNT_ANY)) |-> (out_data.root_first == '0 && !out_data.saturated), "absent root not zero")
    `QRS_ASSERT(a_pipe_advance, clk, rst_n, (va_reg && en) |=> vb_reg, "pipe lost a transaction")
endmodule
`default_nettype wire

// ===== hdl/qrs_sqrt_cell.sv =====
// One cell of the square root chain: settles one result bit per cycle while en is high.
// Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt_cell
    import qrs_pkg::*;
#(
    parameter int STEP = 0
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic en,
    input wire logic vin,
    input wire qrs_work_t din,
    output logic vout,
    output qrs_work_t dout
);
    localparam int BITPOS = SQ_W - 1 - STEP;

    qrs_work_t w_next, w_reg;
    logic v_reg;
    logic [SQ_W+1:0] rem_sh;
    logic [SQ_W+1:0] trial;

    always_comb
    begin
        w_next = din;
        rem_sh = {din.rem[SQ_W-1:0], din.disc[2*BITPOS+1 -: 2]};
        trial = {din.root, 2'b01};
        if (rem_sh >= trial)
        begin
            w_next.rem = rem_sh - trial;
            w_next.root = {din.root[SQ_W-2:0], 1'b1};
        end
        else
        begin
            w_next.rem = rem_sh;
            w_next.root = {din.root[SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

    assign vout = v_reg;
    assign dout = w_reg;
endmodule
`default_nettype wire

// ===== hdl/qrs_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of the two roots.
// Depends on qrs_pkg.
`default_nettype none
module qrs_div_cell
    import qrs_pkg::*;
#(
    parameter int STEP = 0
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic en,
    input wire logic vin,
    input wire qrs_work_t din,
    output logic vout,
    output qrs_work_t dout
);
    localparam int BITPOS = QDIV_W - 1 - STEP;

    qrs_work_t w_next, w_reg;
    logic v_reg;
    logic [QDIV_W:0] s1, s2, dv;

    always_comb
    begin
        w_next = din;
        dv = {{(QDIV_W-COEF_W){1'b0}}, din.den};
        s1 = {din.r1[QDIV_W-1:0], din.n1[BITPOS]};
        s2 = {din.r2[QDIV_W-1:0], din.n2[BITPOS]};
        if (s1 >= dv)
        begin
            w_next.r1 = s1 - dv;
            w_next.q1 = {din.q1[QDIV_W-2:0], 1'b1};
        end
        else
        begin
            w_next.r1 = s1;
            w_next.q1 = {din.q1[QDIV_W-2:0], 1'b0};
        end
        if (s2 >= dv)
        begin
            w_next.r2 = s2 - dv;
            w_next.q2 = {din.q2[QDIV_W-2:0], 1'b1};
        end
        else
        begin
            w_next.r2 = s2;
            w_next.q2 = {din.q2[QDIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

    assign vout = v_reg;
    assign dout = w_reg;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for quadratic_root_solver_unit: directed and random equations,
// predicted results checked in order. Depends on qrs_pkg and the solver RTL.
module tb;
    import qrs_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    qrs_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    qrs_out_t out_data;

    qrs_in_t pending_eq_q[$];
    qrs_out_t root_expect_q[$];
    logic in_took = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_phase = 0;
    int cyc = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    bit stim_done = 1'b0;

    localparam int IDLE_LIMIT = 20000;

    quadratic_root_solver_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] make_root_q(input bit nneg, input logic [127:0] nmag,
                                                input bit dneg, input logic [127:0] dmag,
                                                inout bit sat);
        logic [127:0] quo;
        logic [127:0] lim;
        bit neg;
        begin
            neg = nneg != dneg;
            quo = (nmag << FRAC_W) / dmag;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (quo > lim)
            begin
                quo = lim;
                sat = 1'b1;
            end
            make_root_q = neg ? (~quo[31:0] + 32'd1) : quo[31:0];
        end
    endfunction

    function automatic void sm_add(input bit sx, input logic [127:0] mx, input bit sy,
                                   input logic [127:0] my, output bit sr,
                                   output logic [127:0] mr);
        begin
            if (sx == sy)
            begin
                sr = sx;
                mr = mx + my;
            end
            else if (mx >= my)
            begin
                sr = sx;
                mr = mx - my;
            end
            else
            begin
                sr = sy;
                mr = my - mx;
            end
        end
    endfunction

    function automatic qrs_out_t solve_roots(input qrs_in_t eq);
        qrs_out_t res;
        bit sa, sb, sc, sat, s1, s2;
        logic [127:0] ma, mb, mc, b2, ac4, disc, sq, cand, n1, n2;
        begin
            res = '0;
            sat = 1'b0;
            sa = eq.coef_quad[31];
            sb = eq.coef_lin[31];
            sc = eq.coef_const[31];
            ma = {96'd0, sa ? (~eq.coef_quad + 32'd1) : eq.coef_quad};
            mb = {96'd0, sb ? (~eq.coef_lin + 32'd1) : eq.coef_lin};
            mc = {96'd0, sc ? (~eq.coef_const + 32'd1) : eq.coef_const};
            if (ma != 0)
            begin
                b2 = mb * mb;
                ac4 = (ma * mc) << 2;
                if (sa == sc && ac4 > b2)
                    res.root_count = CNT_NONE;
                else
                begin
                    disc = (sa == sc) ? b2 - ac4 : b2 + ac4;
                    if (disc == 0)
                    begin
                        res.root_count = CNT_ONE;
                        res.root_first = make_root_q(!sb && mb != 0, mb, sa, ma << 1, sat);
                        res.root_second = res.root_first;
                    end
                    else
                    begin
                        sq = 0;
                        for (int i = 63; i >= 0; i--)
                        begin
                            cand = sq | (128'd1 << i);
                            if (cand * cand <= disc)
                                sq = cand;
                        end
                        sm_add(!sb, mb, 1'b0, sq, s1, n1);
                        sm_add(!sb, mb, 1'b1, sq, s2, n2);
                        res.root_count = CNT_TWO;
                        res.root_first = make_root_q(s1, n1, sa, ma << 1, sat);
                        res.root_second = make_root_q(s2, n2, sa, ma << 1, sat);
                    end
                end
            end
            else if (mb != 0)
            begin
                res.root_count = CNT_ONE;
                if (mc != 0)
                    res.root_first = make_root_q(!sc, mc, sb, mb, sat);
            end
            else
                res.root_count = (mc == 0) ? CNT_ANY : CNT_NONE;
            res.saturated = sat;
            solve_roots = res;
        end
    endfunction

    function automatic logic [31:0] rand_coef();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: rand_coef = 32'd0;
                1, 2: rand_coef = $urandom();
                3: rand_coef = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
                4, 5: rand_coef = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                6: rand_coef = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                7: rand_coef = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
                default: rand_coef = $signed($urandom_range(0, 2000)) - 1000;
            endcase
        end
    endfunction

    task automatic add_eq(input logic [31:0] qa, input logic [31:0] lb, input logic [31:0] kc);
        qrs_in_t eq;
        begin
            eq.coef_quad = qa;
            eq.coef_lin = lb;
            eq.coef_const = kc;
            pending_eq_q.push_back(eq);
        end
    endtask

    initial
    begin
        int m, k;
        add_eq(0, 0, 0);
        add_eq(0, 0, 32'h0001_0000);
        add_eq(0, 0, 32'h8000_0000);
        add_eq(0, 32'h0001_0000, 0);
        add_eq(0, 32'h0001_0000, 32'h0003_0000);
        add_eq(0, 1, 32'h7fff_ffff);
        add_eq(0, 32'hffff_ffff, 32'h8000_0000);
        add_eq(0, 32'h8000_0000, 32'h7fff_ffff);
        add_eq(32'h0001_0000, 0, 32'hffff_0000);
        add_eq(32'hffff_0000, 0, 32'h0001_0000);
        add_eq(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
        add_eq(32'hffff_0000, 32'h0002_0000, 32'hffff_0000);
        add_eq(32'h0001_0000, 0, 32'h0001_0000);
        add_eq(32'hffff_0000, 32'h0003_0000, 32'h0002_0000);
        add_eq(1, 32'h7fff_ffff, 32'h8000_0000);
        add_eq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_eq(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        add_eq(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        add_eq(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        add_eq(1, 0, 32'h8000_0000);
        add_eq(32'hffff_ffff, 32'hffff_ffff, 0);
        add_eq(1, 1, 1);
        for (int n = 0; n < 1800; n++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                m = $signed($urandom_range(1, 4000)) - 2000;
                if (m == 0)
                    m = 7;
                k = $signed($urandom_range(0, 600)) - 300;
                add_eq(m, 2 * m * k, m * k * k);
            end
            else
                add_eq(rand_coef(), rand_coef(), rand_coef());
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pending_eq_q.size() == 0 && !in_valid);
        wait (root_expect_q.size() == 0);
        repeat (300) @(posedge clk);
        stim_done = 1'b1;
        if (mismatches == 0 && root_expect_q.size() == 0)
            $display("PASS quadratic_root_solver_unit");
        else
            $display("FAIL quadratic_root_solver_unit");
        $finish;
    end

    always @(negedge clk)
    begin
        bit nxt_valid;
        qrs_in_t nxt_data;
        nxt_valid = in_valid;
        nxt_data = in_data;
        cyc++;
        if (rst_n && !(in_valid && !in_took))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_eq_q.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_data = pending_eq_q.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        in_valid <= nxt_valid;
        in_data <= nxt_data;
        if (cyc % 500 == 0)
            stall_phase = $urandom_range(0, 2);
        case (stall_phase)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ((cyc / 7) % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        qrs_out_t exp_res;
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                root_expect_q.push_back(solve_roots(in_data));
            if (out_valid && out_ready)
            begin
                if (root_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction: %p", out_data);
                end
                else
                begin
                    exp_res = root_expect_q.pop_front();
                    if (out_data.root_count !== exp_res.root_count
                        || out_data.root_first !== exp_res.root_first
                        || out_data.root_second !== exp_res.root_second
                        || out_data.saturated !== exp_res.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, got %p", exp_res, out_data);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT && !stim_done)
            begin
                $display("FAIL quadratic_root_solver_unit");
                $finish;
            end
        end
    end
endmodule
